### hdl/hkvt_pkg.sv
package hkvt_pkg;

  localparam int OUT_W     = 24;
  localparam int RES_NUM   = 11;
  localparam int RES_MAX   = 20;
  localparam int RES_LEN_W = 5;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_KEY    = 3'd0,
    ERR_BAD_KEY   = 3'd1,
    ERR_RESERVED  = 3'd2,
    ERR_BAD_SEP   = 3'd3,
    ERR_EMPTY     = 3'd4,
    ERR_NO_COLON  = 3'd5,
    ERR_NO_VALUE  = 3'd6,
    ERR_NO_EOL    = 3'd7
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] key_start;
    logic [OUT_W-1:0] key_length;
    logic [OUT_W-1:0] span_start;
    logic [OUT_W-1:0] span_length;
    err_t             error_code;
    logic [OUT_W-1:0] error_position;
  } res_t;

  // handshake between pipeline stages
  typedef struct packed {
    logic valid;
    logic take;
  } hs_t;

  // names right-justified, zero padded on the left
  localparam logic [8*RES_MAX-1:0] RES_NAME [RES_NUM] = '{
    160'("FILENAME"),
    160'("CONTENT"),
    160'({"DATE_", "FORMATTED"}),
    160'({"DATE_", "FIRST_FORMATTED"}),
    160'({"DATE_", "LAST_FORMATTED"}),
    160'({"PAGE_", "FIRST"}),
    160'({"PAGE_", "PREVIOUS"}),
    160'({"PAGE_", "CURRENT"}),
    160'({"PAGE_", "NEXT"}),
    160'({"PAGE_", "LAST"}),
    160'({8'h42, 8'h4C, 8'h4F, 8'h47, 8'h43, "_VERSION"})
  };

  localparam logic [RES_LEN_W-1:0] RES_LEN [RES_NUM] = '{
    5'd8, 5'd7, 5'd14, 5'd20, 5'd19, 5'd10, 5'd13, 5'd12, 5'd9, 5'd9, 5'd13
  };

endpackage

### hdl/hkvt_in_stage.sv
module hkvt_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hkvt_pkg::item_t in_item,
  output hkvt_pkg::hs_t  s1_hs_valid,
  input  logic           s1_take,
  output hkvt_pkg::item_t s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  hkvt_pkg::item_t item_r;

  assign in_ready = !valid_r || s1_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_hs_valid.valid = valid_r;
  assign s1_hs_valid.take  = s1_take;
  assign s1_item           = item_r;

endmodule

### hdl/hkvt_parser.sv
module hkvt_parser #(
  parameter int OFFSET_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hkvt_pkg::hs_t   s1_hs,
  input  hkvt_pkg::item_t s1_item,
  output logic            res_valid,
  output hkvt_pkg::res_t  res
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [hkvt_pkg::RES_NUM-1:0] ALIVE_ALL = {hkvt_pkg::RES_NUM{1'b1}};

  typedef enum logic [6:0] {
    MODE_START   = 7'b0000001,
    MODE_KEY     = 7'b0000010,
    MODE_VSTART  = 7'b0000100,
    MODE_VALUE   = 7'b0001000,
    MODE_SEP     = 7'b0010000,
    MODE_CSTART  = 7'b0100000,
    MODE_CONTENT = 7'b1000000
  } mode_t;

  mode_t                        mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0]       byte_offset_r, byte_offset_nxt;
  logic [OFFSET_BITS-1:0]       key_begin_r, key_begin_nxt;
  logic [OFFSET_BITS-1:0]       key_count_r, key_count_nxt;
  logic [OFFSET_BITS-1:0]       span_begin_r, span_begin_nxt;
  logic [OFFSET_BITS-1:0]       first_nb_r, first_nb_nxt;
  logic [OFFSET_BITS-1:0]       last_nb_r, last_nb_nxt;
  logic                         seen_nb_r, seen_nb_nxt;
  logic [hkvt_pkg::RES_NUM-1:0] alive_r, alive_nxt;
  logic                         entry_seen_r, entry_seen_nxt;
  logic                         halted_r, halted_nxt;

  logic                         go;
  logic [7:0]                   c;
  logic                         last;
  logic [OFFSET_BITS-1:0]       pos;
  logic                         is_upper, is_digit, is_eol, is_blank, is_key_ch;
  logic [hkvt_pkg::RES_NUM-1:0] alive_first, alive_match;
  logic                         key_reserved;
  logic [7:0]                   name_ch [hkvt_pkg::RES_NUM];

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic logic [hkvt_pkg::OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
    return hkvt_pkg::OUT_W'(32'(v));
  endfunction

  assign c    = s1_item.data_byte;
  assign last = s1_item.last_byte;
  assign pos  = byte_offset_r;

  assign is_upper  = (c >= 8'h41) && (c <= 8'h5A);
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign is_eol    = (c == 8'h0A) || (c == 8'h0D);
  assign is_blank  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  assign is_key_ch = is_upper || is_digit || (c == 8'h5F);

  // reserved-name matching, one lane per name
  always_comb begin
    key_reserved = 1'b0;
    for (int i = 0; i < hkvt_pkg::RES_NUM; i++) begin
      alive_first[i] = (hkvt_pkg::RES_NAME[i][8*(int'(hkvt_pkg::RES_LEN[i]) - 1) +: 8] == c);
      name_ch[i]     = 8'h00;
      alive_match[i] = 1'b0;
      if (key_count_r < OFFSET_BITS'(hkvt_pkg::RES_LEN[i])) begin
        name_ch[i] = hkvt_pkg::RES_NAME[i][8*(int'(hkvt_pkg::RES_LEN[i]) - 1
                     - int'(key_count_r[hkvt_pkg::RES_LEN_W-1:0])) +: 8];
        alive_match[i] = alive_r[i] && (name_ch[i] == c);
      end
      if (alive_r[i] && (key_count_r == OFFSET_BITS'(hkvt_pkg::RES_LEN[i]))) begin
        key_reserved = 1'b1;
      end
    end
  end

  assign go = s1_hs.valid && s1_hs.take;

  always_comb begin
    mode_nxt        = mode_r;
    byte_offset_nxt = byte_offset_r;
    key_begin_nxt   = key_begin_r;
    key_count_nxt   = key_count_r;
    span_begin_nxt  = span_begin_r;
    first_nb_nxt    = first_nb_r;
    last_nb_nxt     = last_nb_r;
    seen_nb_nxt     = seen_nb_r;
    alive_nxt       = alive_r;
    entry_seen_nxt  = entry_seen_r;
    halted_nxt      = halted_r;
    res_valid       = 1'b0;
    res             = '0;

    if (!halted_r) begin
      case (mode_r)
        MODE_START: begin
          if (c == 8'h20 || c == 8'h09 || is_eol) begin
            mode_nxt = MODE_START;
          end else if (is_upper) begin
            mode_nxt      = MODE_KEY;
            key_begin_nxt = pos;
            key_count_nxt = OFFSET_BITS'(1);
            alive_nxt     = alive_first;
          end else if (c == 8'h2D) begin
            mode_nxt = MODE_SEP;
          end else begin
            halted_nxt         = 1'b1;
            res_valid          = 1'b1;
            res.kind           = hkvt_pkg::KIND_ERROR;
            res.error_code     = hkvt_pkg::ERR_NO_KEY;
            res.error_position = to_out(pos);
          end
        end
        MODE_KEY: begin
          if (is_key_ch) begin
            alive_nxt     = alive_match;
            key_count_nxt = sat_inc(key_count_r);
          end else if (c == 8'h3A && !key_reserved) begin
            mode_nxt = MODE_VSTART;
          end else begin
            halted_nxt         = 1'b1;
            res_valid          = 1'b1;
            res.kind           = hkvt_pkg::KIND_ERROR;
            res.error_code     = (c == 8'h3A) ? hkvt_pkg::ERR_RESERVED
                                              : hkvt_pkg::ERR_BAD_KEY;
            res.error_position = to_out(pos);
          end
        end
        MODE_VSTART: begin
          if (is_eol) begin
            res_valid      = 1'b1;
            res.kind       = hkvt_pkg::KIND_ENTRY;
            res.key_start  = to_out(key_begin_r);
            res.key_length = to_out(key_count_r);
            res.span_start = to_out(pos);
            entry_seen_nxt = 1'b1;
            mode_nxt       = MODE_START;
          end else begin
            mode_nxt       = MODE_VALUE;
            span_begin_nxt = pos;
            seen_nb_nxt    = !is_blank;
            first_nb_nxt   = pos;
            last_nb_nxt    = pos;
          end
        end
        MODE_VALUE: begin
          if (is_eol) begin
            res_valid      = 1'b1;
            res.kind       = hkvt_pkg::KIND_ENTRY;
            res.key_start  = to_out(key_begin_r);
            res.key_length = to_out(key_count_r);
            if (seen_nb_r) begin
              res.span_start  = to_out(first_nb_r);
              res.span_length = to_out(sat_inc(last_nb_r - first_nb_r));
            end else begin
              res.span_start  = to_out(span_begin_r);
            end
            entry_seen_nxt = 1'b1;
            mode_nxt       = MODE_START;
          end else if (!is_blank) begin
            if (!seen_nb_r) begin
              first_nb_nxt = pos;
            end
            seen_nb_nxt = 1'b1;
            last_nb_nxt = pos;
          end
        end
        MODE_SEP: begin
          if (is_eol) begin
            mode_nxt = MODE_CSTART;
          end else if (c != 8'h2D) begin
            halted_nxt         = 1'b1;
            res_valid          = 1'b1;
            res.kind           = hkvt_pkg::KIND_ERROR;
            res.error_code     = hkvt_pkg::ERR_BAD_SEP;
            res.error_position = to_out(pos);
          end
        end
        MODE_CSTART: begin
          if (!is_eol) begin
            span_begin_nxt = pos;
            mode_nxt       = MODE_CONTENT;
          end
        end
        MODE_CONTENT: begin
          if (last) begin
            res_valid       = 1'b1;
            res.kind        = hkvt_pkg::KIND_CONTENT;
            res.span_start  = to_out(span_begin_r);
            res.span_length = to_out(sat_inc(pos - span_begin_r));
            entry_seen_nxt  = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_START;
        end
      endcase
    end

    if (last) begin
      // end of input with nothing reported in this source
      if (!halted_nxt && !entry_seen_nxt) begin
        res.kind           = hkvt_pkg::KIND_ERROR;
        res.error_position = to_out(sat_inc(pos));
        case (mode_nxt)
          MODE_START: begin
            res_valid      = 1'b1;
            res.error_code = hkvt_pkg::ERR_EMPTY;
          end
          MODE_KEY: begin
            res_valid      = 1'b1;
            res.error_code = hkvt_pkg::ERR_NO_COLON;
          end
          MODE_VSTART: begin
            res_valid      = 1'b1;
            res.error_code = hkvt_pkg::ERR_NO_VALUE;
          end
          MODE_VALUE: begin
            res_valid      = 1'b1;
            res.error_code = hkvt_pkg::ERR_NO_EOL;
          end
          default: begin
            res_valid = 1'b0;
            res       = '0;
          end
        endcase
      end
      mode_nxt        = MODE_START;
      byte_offset_nxt = '0;
      key_begin_nxt   = '0;
      key_count_nxt   = '0;
      span_begin_nxt  = '0;
      first_nb_nxt    = '0;
      last_nb_nxt     = '0;
      seen_nb_nxt     = 1'b0;
      alive_nxt       = ALIVE_ALL;
      entry_seen_nxt  = 1'b0;
      halted_nxt      = 1'b0;
    end else begin
      byte_offset_nxt = sat_inc(byte_offset_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_START;
      byte_offset_r <= '0;
      key_begin_r   <= '0;
      key_count_r   <= '0;
      span_begin_r  <= '0;
      first_nb_r    <= '0;
      last_nb_r     <= '0;
      seen_nb_r     <= 1'b0;
      alive_r       <= ALIVE_ALL;
      entry_seen_r  <= 1'b0;
      halted_r      <= 1'b0;
    end else if (go) begin
      mode_r        <= mode_nxt;
      byte_offset_r <= byte_offset_nxt;
      key_begin_r   <= key_begin_nxt;
      key_count_r   <= key_count_nxt;
      span_begin_r  <= span_begin_nxt;
      first_nb_r    <= first_nb_nxt;
      last_nb_r     <= last_nb_nxt;
      seen_nb_r     <= seen_nb_nxt;
      alive_r       <= alive_nxt;
      entry_seen_r  <= entry_seen_nxt;
      halted_r      <= halted_nxt;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && s1_hs.valid && !s1_item.last_byte |-> !res_valid)
    else $error("result produced while halted");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    go && s1_item.last_byte |=> mode_r == MODE_START && !halted_r && byte_offset_r == '0)
    else $error("parser not back at start after last byte");

  a_offset_mono: assert property (@(posedge clk) disable iff (!rst_n)
    go && !s1_item.last_byte |=> byte_offset_r >= $past(byte_offset_r))
    else $error("byte offset went backwards");

  a_entry_key: assert property (@(posedge clk) disable iff (!rst_n)
    s1_hs.valid && res_valid && res.kind == hkvt_pkg::KIND_ENTRY |-> res.key_length != '0)
    else $error("header entry with empty key");

endmodule

### hdl/hkvt_out_stage.sv
module hkvt_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_load,
  input  hkvt_pkg::res_t res,
  output logic           out_free,
  output logic           out_valid,
  input  logic           out_ready,
  output hkvt_pkg::res_t out_res
);

  logic           valid_r;
  logic           valid_nxt;
  hkvt_pkg::res_t res_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### hdl/header_key_value_tokenizer_core.sv
// a byte waits in the input register; its result, if any, goes to the result register
// throughput: one byte per cycle, stalled while a result waits for the result register
// the parser state updates once per accepted byte; the two registers decouple the channels
// reset: rst_n synchronous, active low; clears pipeline valids and parser state
// the parser also returns to its start state after every last byte
module header_key_value_tokenizer_core #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [hkvt_pkg::OUT_W-1:0]    out_key_start,
  output logic [hkvt_pkg::OUT_W-1:0]    out_key_length,
  output logic [hkvt_pkg::OUT_W-1:0]    out_span_start,
  output logic [hkvt_pkg::OUT_W-1:0]    out_span_length,
  output logic [2:0]                    out_error_code,
  output logic [hkvt_pkg::OUT_W-1:0]    out_error_position
);

  hkvt_pkg::item_t in_item;
  hkvt_pkg::item_t s1_item;
  hkvt_pkg::hs_t   s1_hs;
  hkvt_pkg::res_t  res;
  hkvt_pkg::res_t  out_res;
  logic            res_valid;
  logic            out_free;
  logic            s1_take;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // a byte that yields no result moves on even while the output is stalled
  assign s1_take = s1_hs.valid && (!res_valid || out_free);

  hkvt_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .s1_hs_valid (s1_hs),
    .s1_take     (s1_take),
    .s1_item     (s1_item)
  );

  hkvt_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_hs     (s1_hs),
    .s1_item   (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  hkvt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (s1_take && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_key_start      = out_res.key_start;
  assign out_key_length     = out_res.key_length;
  assign out_span_start     = out_res.span_start;
  assign out_span_length    = out_res.span_length;
  assign out_error_code     = out_res.error_code;
  assign out_error_position = out_res.error_position;

endmodule
